[hdl/ivf_pkg.sv]
package ivf_pkg;

    localparam int DATA_W = 48;
    localparam int SIG_W  = 47;
    localparam int VAR_W  = 2 * SIG_W;
    localparam int SUM_W  = VAR_W + 1;
    localparam int ROOT_W = VAR_W / 2;
    localparam int LO_W   = 24;
    localparam int HI_W   = SIG_W - LO_W;

    // register stages of the front, the blend and the output, outside the parameter dependent division
    localparam int FRONT_STAGES = 3;
    localparam int BLEND_STAGES = 3;
    localparam int OUT_STAGES   = 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] meas_a;
        logic        [SIG_W-1:0]  sigma_a;
        logic signed [DATA_W-1:0] err_a;
        logic signed [DATA_W-1:0] meas_b;
        logic        [SIG_W-1:0]  sigma_b;
        logic signed [DATA_W-1:0] err_b;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] fused_meas;
        logic        [SIG_W-1:0]  fused_sigma;
        logic signed [DATA_W-1:0] fused_err;
        logic                     degenerate;
    } out_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] fused_meas;
        logic signed [DATA_W-1:0] fused_err;
        logic                     degenerate;
    } blend_word_t;

endpackage

[hdl/inverse_variance_fusion.sv]
// channel   signals               word type    handshake
// input     start, busy, item     in_word_t    taken when start && !busy
// result    done, result          out_word_t   one cycle, taken the same edge
//
// one word enters per cycle, every cycle; busy stays low
// each word passes the front, the alpha divider (FRAC_BITS + 1
// stages), the blend, the muldiv (two stages per bit of the 94 bit
// variance), the square root (47 stages) and the output register
// reset clears only the valid bits; words in flight are dropped
// the receiver cannot stall, so nothing is held back
module inverse_variance_fusion #(
    parameter int FRAC_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ivf_pkg::in_word_t     item,
    output logic                  done,
    output ivf_pkg::out_word_t    result
);
    localparam int VW = ivf_pkg::VAR_W;
    localparam int SW = ivf_pkg::SUM_W;
    localparam int RW = ivf_pkg::ROOT_W;

    logic                   f_vld;
    ivf_pkg::in_word_t      f_word;
    logic [VW-1:0]          f_va, f_vb;
    logic [SW-1:0]          f_sum;

    logic                   a_vld;
    ivf_pkg::blend_word_t   a_word;
    logic [VW-1:0]          a_va, a_vb;
    logic [SW-1:0]          a_sum;

    logic                   m_vld;
    ivf_pkg::blend_word_t   m_word;
    logic [VW-1:0]          m_quot;

    logic                   r_vld;
    ivf_pkg::blend_word_t   r_word;
    logic [RW-1:0]          r_root;

    logic                   done_reg;
    ivf_pkg::out_word_t     result_reg;
    ivf_pkg::out_word_t     result_next;

    ivf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start && !busy),
        .in_word  (item),
        .out_vld  (f_vld),
        .out_word (f_word),
        .var_a    (f_va),
        .var_b    (f_vb),
        .var_sum  (f_sum)
    );

    ivf_alpha #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (f_vld),
        .in_word   (f_word),
        .var_a     (f_va),
        .var_b     (f_vb),
        .var_sum   (f_sum),
        .out_vld   (a_vld),
        .out_word  (a_word),
        .out_var_a (a_va),
        .out_var_b (a_vb),
        .out_sum   (a_sum)
    );

    ivf_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (a_vld),
        .in_word  (a_word),
        .var_a    (a_va),
        .var_b    (a_vb),
        .var_sum  (a_sum),
        .out_vld  (m_vld),
        .out_word (m_word),
        .quot     (m_quot)
    );

    ivf_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (m_vld),
        .in_word  (m_word),
        .radicand (m_quot),
        .out_vld  (r_vld),
        .out_word (r_word),
        .root     (r_root)
    );

    // zero sum leaves the root meaningless, force it
    always_comb
    begin
        result_next.fused_meas  = r_word.fused_meas;
        result_next.fused_sigma = r_word.degenerate ? '0 : r_root;
        result_next.fused_err   = r_word.fused_err;
        result_next.degenerate  = r_word.degenerate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/ivf_front.sv]
module ivf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  ivf_pkg::in_word_t            in_word,
    output logic                         out_vld,
    output ivf_pkg::in_word_t            out_word,
    output logic [ivf_pkg::VAR_W-1:0]    var_a,
    output logic [ivf_pkg::VAR_W-1:0]    var_b,
    output logic [ivf_pkg::SUM_W-1:0]    var_sum
);
    localparam int VW = ivf_pkg::VAR_W;
    localparam int SW = ivf_pkg::SUM_W;
    localparam int LW = ivf_pkg::LO_W;
    localparam int HW = ivf_pkg::HI_W;

    logic [2:0] vld_reg;
    ivf_pkg::in_word_t word_reg [3];

    logic [2*HW-1:0]    hh_a_reg, hh_b_reg;
    logic [HW+LW-1:0]   hl_a_reg, hl_b_reg;
    logic [2*LW-1:0]    ll_a_reg, ll_b_reg;
    logic [VW-1:0]      va_reg, vb_reg, va2_reg, vb2_reg;
    logic [SW-1:0]      sum_reg;
    logic [VW-1:0]      va_next, vb_next;

    // square from half products: hi^2 << 2L + hi*lo << (L+1) + lo^2
    always_comb
    begin
        va_next = (VW'(hh_a_reg) << (2 * LW)) + (VW'(hl_a_reg) << (LW + 1)) + VW'(ll_a_reg);
        vb_next = (VW'(hh_b_reg) << (2 * LW)) + (VW'(hl_b_reg) << (LW + 1)) + VW'(ll_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg[0] <= in_word;
        word_reg[1] <= word_reg[0];
        word_reg[2] <= word_reg[1];
        hh_a_reg    <= (2*HW)'(in_word.sigma_a[HW+LW-1:LW])
                       * (2*HW)'(in_word.sigma_a[HW+LW-1:LW]);
        hl_a_reg    <= (HW+LW)'(in_word.sigma_a[HW+LW-1:LW])
                       * (HW+LW)'(in_word.sigma_a[LW-1:0]);
        ll_a_reg    <= (2*LW)'(in_word.sigma_a[LW-1:0]) * (2*LW)'(in_word.sigma_a[LW-1:0]);
        hh_b_reg    <= (2*HW)'(in_word.sigma_b[HW+LW-1:LW])
                       * (2*HW)'(in_word.sigma_b[HW+LW-1:LW]);
        hl_b_reg    <= (HW+LW)'(in_word.sigma_b[HW+LW-1:LW])
                       * (HW+LW)'(in_word.sigma_b[LW-1:0]);
        ll_b_reg    <= (2*LW)'(in_word.sigma_b[LW-1:0]) * (2*LW)'(in_word.sigma_b[LW-1:0]);
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        va2_reg     <= va_reg;
        vb2_reg     <= vb_reg;
        sum_reg     <= SW'(va_reg) + SW'(vb_reg);
    end

    assign out_vld  = vld_reg[2];
    assign out_word = word_reg[2];
    assign var_a    = va2_reg;
    assign var_b    = vb2_reg;
    assign var_sum  = sum_reg;

endmodule

[hdl/ivf_alpha.sv]
module ivf_alpha #(
    parameter int FRAC_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  ivf_pkg::in_word_t            in_word,
    input  logic [ivf_pkg::VAR_W-1:0]    var_a,
    input  logic [ivf_pkg::VAR_W-1:0]    var_b,
    input  logic [ivf_pkg::SUM_W-1:0]    var_sum,
    output logic                         out_vld,
    output ivf_pkg::blend_word_t         out_word,
    output logic [ivf_pkg::VAR_W-1:0]    out_var_a,
    output logic [ivf_pkg::VAR_W-1:0]    out_var_b,
    output logic [ivf_pkg::SUM_W-1:0]    out_sum
);
    localparam int VW = ivf_pkg::VAR_W;
    localparam int SW = ivf_pkg::SUM_W;
    localparam int DW = ivf_pkg::DATA_W;
    localparam int AW = FRAC_BITS + 1;
    localparam int NS = FRAC_BITS + 1;
    localparam int XW = DW + 1;
    localparam int QW = XW - FRAC_BITS;
    localparam int PW = AW + 1 + QW;
    localparam int RW = AW + FRAC_BITS;
    localparam int BS = ivf_pkg::BLEND_STAGES;
    localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

    // restoring division var_b * 2^F / sum, one quotient bit per stage
    logic [NS-1:0]     dvld_reg;
    logic [SW-1:0]     rem_reg [NS];
    logic [AW-1:0]     alp_reg [NS];
    logic [VW-1:0]     va_reg [NS];
    logic [VW-1:0]     vb_reg [NS];
    logic [SW-1:0]     s_reg [NS];
    ivf_pkg::in_word_t word_reg [NS];

    logic [SW-1:0]     rem_in [NS];
    logic [AW-1:0]     alp_in [NS];
    logic [VW-1:0]     va_in [NS];
    logic [VW-1:0]     vb_in [NS];
    logic [SW-1:0]     s_in [NS];
    ivf_pkg::in_word_t word_in [NS];
    logic [SW-1:0]     rem_next [NS];
    logic [AW-1:0]     alp_next [NS];

    always_comb
    begin
        rem_in[0]  = SW'(var_b);
        alp_in[0]  = '0;
        va_in[0]   = var_a;
        vb_in[0]   = var_b;
        s_in[0]    = var_sum;
        word_in[0] = in_word;
        for (int k = 1; k < NS; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            alp_in[k]  = alp_reg[k-1];
            va_in[k]   = va_reg[k-1];
            vb_in[k]   = vb_reg[k-1];
            s_in[k]    = s_reg[k-1];
            word_in[k] = word_reg[k-1];
        end
    end

    always_comb
    begin
        logic [SW:0] part;
        logic [SW:0] diff;
        logic        ge;
        for (int k = 0; k < NS; k++)
        begin
            // first stage gives the integer bit, so no shift there
            if (k == 0)
                part = {1'b0, rem_in[k]};
            else
                part = {rem_in[k], 1'b0};
            diff        = part - {1'b0, s_in[k]};
            ge          = (part >= {1'b0, s_in[k]});
            rem_next[k] = ge ? diff[SW-1:0] : part[SW-1:0];
            alp_next[k] = {alp_in[k][AW-2:0], ge};
        end
    end

    // blend: xb + alpha * (xa - xb) >> F, split into whole and fraction parts
    logic [BS-1:0]          bvld_reg;
    logic [VW-1:0]          va_pt_reg [BS];
    logic [VW-1:0]          vb_pt_reg [BS];
    logic [SW-1:0]          s_pt_reg [BS];

    logic [AW-1:0]          alpha_b1_reg;
    logic signed [XW-1:0]   dm_b1_reg, de_b1_reg;
    logic signed [DW-1:0]   mb_b1_reg, eb_b1_reg, mb_b2_reg, eb_b2_reg;
    logic                   degen_b1_reg, degen_b2_reg;
    logic signed [PW-1:0]   pq_m_reg, pq_e_reg;
    logic [RW-1:0]          pr_m_reg, pr_e_reg;
    ivf_pkg::blend_word_t   out_reg;

    logic                   degen_next;
    logic [AW-1:0]          alpha_next;
    logic signed [XW-1:0]   dm_next, de_next;
    logic signed [QW-1:0]   qm, qe;
    logic signed [PW-1:0]   pq_m_next, pq_e_next;
    logic [RW-1:0]          pr_m_next, pr_e_next;
    logic signed [PW-1:0]   ym, ye;
    ivf_pkg::blend_word_t   out_next;

    always_comb
    begin
        degen_next = (s_reg[NS-1] == '0);
        alpha_next = degen_next ? HALF : alp_reg[NS-1];
        dm_next    = XW'($signed(word_reg[NS-1].meas_a)) - XW'($signed(word_reg[NS-1].meas_b));
        de_next    = XW'($signed(word_reg[NS-1].err_a)) - XW'($signed(word_reg[NS-1].err_b));

        qm         = $signed(dm_b1_reg[XW-1:FRAC_BITS]);
        qe         = $signed(de_b1_reg[XW-1:FRAC_BITS]);
        pq_m_next  = PW'($signed({1'b0, alpha_b1_reg})) * PW'(qm);
        pq_e_next  = PW'($signed({1'b0, alpha_b1_reg})) * PW'(qe);
        pr_m_next  = RW'(alpha_b1_reg) * RW'(dm_b1_reg[FRAC_BITS-1:0]);
        pr_e_next  = RW'(alpha_b1_reg) * RW'(de_b1_reg[FRAC_BITS-1:0]);

        ym = pq_m_reg + $signed({{(PW-AW){1'b0}}, pr_m_reg[RW-1:FRAC_BITS]})
             + PW'(mb_b2_reg);
        ye = pq_e_reg + $signed({{(PW-AW){1'b0}}, pr_e_reg[RW-1:FRAC_BITS]})
             + PW'(eb_b2_reg);
        out_next.fused_meas = ym[DW-1:0];
        out_next.fused_err  = ye[DW-1:0];
        out_next.degenerate = degen_b2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
            bvld_reg <= '0;
        end
        else
        begin
            dvld_reg <= {dvld_reg[NS-2:0], in_vld};
            bvld_reg <= {bvld_reg[BS-2:0], dvld_reg[NS-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            alp_reg[k]  <= alp_next[k];
            va_reg[k]   <= va_in[k];
            vb_reg[k]   <= vb_in[k];
            s_reg[k]    <= s_in[k];
            word_reg[k] <= word_in[k];
        end
        va_pt_reg[0] <= va_reg[NS-1];
        vb_pt_reg[0] <= vb_reg[NS-1];
        s_pt_reg[0]  <= s_reg[NS-1];
        for (int k = 1; k < BS; k++)
        begin
            va_pt_reg[k] <= va_pt_reg[k-1];
            vb_pt_reg[k] <= vb_pt_reg[k-1];
            s_pt_reg[k]  <= s_pt_reg[k-1];
        end
        alpha_b1_reg <= alpha_next;
        dm_b1_reg    <= dm_next;
        de_b1_reg    <= de_next;
        mb_b1_reg    <= word_reg[NS-1].meas_b;
        eb_b1_reg    <= word_reg[NS-1].err_b;
        degen_b1_reg <= degen_next;
        pq_m_reg     <= pq_m_next;
        pq_e_reg     <= pq_e_next;
        pr_m_reg     <= pr_m_next;
        pr_e_reg     <= pr_e_next;
        mb_b2_reg    <= mb_b1_reg;
        eb_b2_reg    <= eb_b1_reg;
        degen_b2_reg <= degen_b1_reg;
        out_reg      <= out_next;
    end

    assign out_vld   = bvld_reg[BS-1];
    assign out_word  = out_reg;
    assign out_var_a = va_pt_reg[BS-1];
    assign out_var_b = vb_pt_reg[BS-1];
    assign out_sum   = s_pt_reg[BS-1];

endmodule

[hdl/ivf_muldiv.sv]
module ivf_muldiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  ivf_pkg::blend_word_t         in_word,
    input  logic [ivf_pkg::VAR_W-1:0]    var_a,
    input  logic [ivf_pkg::VAR_W-1:0]    var_b,
    input  logic [ivf_pkg::SUM_W-1:0]    var_sum,
    output logic                         out_vld,
    output ivf_pkg::blend_word_t         out_word,
    output logic [ivf_pkg::VAR_W-1:0]    quot
);
    localparam int VW = ivf_pkg::VAR_W;
    localparam int SW = ivf_pkg::SUM_W;
    localparam int NS = 2 * VW;

    // var_a * var_b / sum without the product: per bit of var_b a
    // doubling stage and an add stage, remainder kept below sum
    logic [NS-1:0]          vld_reg;
    logic [SW-1:0]          rem_reg [NS];
    logic [VW-1:0]          quot_reg [NS];
    logic [VW-1:0]          va_reg [NS];
    logic [VW-1:0]          vb_reg [NS];
    logic [SW-1:0]          s_reg [NS];
    ivf_pkg::blend_word_t   word_reg [NS];

    logic [SW-1:0]          rem_in [NS];
    logic [VW-1:0]          quot_in [NS];
    logic [VW-1:0]          va_in [NS];
    logic [VW-1:0]          vb_in [NS];
    logic [SW-1:0]          s_in [NS];
    ivf_pkg::blend_word_t   word_in [NS];
    logic [SW-1:0]          rem_next [NS];
    logic [VW-1:0]          quot_next [NS];

    always_comb
    begin
        rem_in[0]  = '0;
        quot_in[0] = '0;
        va_in[0]   = var_a;
        vb_in[0]   = var_b;
        s_in[0]    = var_sum;
        word_in[0] = in_word;
        for (int k = 1; k < NS; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            quot_in[k] = quot_reg[k-1];
            va_in[k]   = va_reg[k-1];
            vb_in[k]   = vb_reg[k-1];
            s_in[k]    = s_reg[k-1];
            word_in[k] = word_reg[k-1];
        end
    end

    always_comb
    begin
        logic [SW:0] part;
        logic [SW:0] diff;
        logic        ge;
        for (int k = 0; k < NS; k++)
        begin
            if ((k & 1) == 0)
                part = {rem_in[k], 1'b0};
            else if (vb_in[k][VW-1-(k>>1)])
                part = {1'b0, rem_in[k]} + (SW+1)'(va_in[k]);
            else
                part = {1'b0, rem_in[k]};
            diff        = part - {1'b0, s_in[k]};
            ge          = (part >= {1'b0, s_in[k]});
            rem_next[k] = ge ? diff[SW-1:0] : part[SW-1:0];
            if ((k & 1) == 0)
                quot_next[k] = {quot_in[k][VW-2:0], ge};
            else
                quot_next[k] = quot_in[k] + VW'(ge);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            quot_reg[k] <= quot_next[k];
            va_reg[k]   <= va_in[k];
            vb_reg[k]   <= vb_in[k];
            s_reg[k]    <= s_in[k];
            word_reg[k] <= word_in[k];
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_word = word_reg[NS-1];
    assign quot     = quot_reg[NS-1];

endmodule

[hdl/ivf_isqrt.sv]
module ivf_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  ivf_pkg::blend_word_t         in_word,
    input  logic [ivf_pkg::VAR_W-1:0]    radicand,
    output logic                         out_vld,
    output ivf_pkg::blend_word_t         out_word,
    output logic [ivf_pkg::ROOT_W-1:0]   root
);
    localparam int VW = ivf_pkg::VAR_W;
    localparam int RW = ivf_pkg::ROOT_W;
    localparam int MW = RW + 2;
    localparam int TW = RW + 4;
    localparam int NS = RW;

    // digit by digit root, two radicand bits per stage
    logic [NS-1:0]          vld_reg;
    logic [VW-1:0]          rad_reg [NS];
    logic [RW-1:0]          root_reg [NS];
    logic [MW-1:0]          rem_reg [NS];
    ivf_pkg::blend_word_t   word_reg [NS];

    logic [VW-1:0]          rad_in [NS];
    logic [RW-1:0]          root_in [NS];
    logic [MW-1:0]          rem_in [NS];
    ivf_pkg::blend_word_t   word_in [NS];
    logic [RW-1:0]          root_next [NS];
    logic [MW-1:0]          rem_next [NS];

    always_comb
    begin
        rad_in[0]  = radicand;
        root_in[0] = '0;
        rem_in[0]  = '0;
        word_in[0] = in_word;
        for (int k = 1; k < NS; k++)
        begin
            rad_in[k]  = rad_reg[k-1];
            root_in[k] = root_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            word_in[k] = word_reg[k-1];
        end
    end

    always_comb
    begin
        logic [TW-1:0] part;
        logic [TW-1:0] trial;
        logic [TW-1:0] diff;
        logic          ge;
        for (int k = 0; k < NS; k++)
        begin
            part         = {rem_in[k], rad_in[k][VW-2-2*k +: 2]};
            trial        = TW'({root_in[k], 2'b01});
            diff         = part - trial;
            ge           = (part >= trial);
            rem_next[k]  = ge ? diff[MW-1:0] : part[MW-1:0];
            root_next[k] = {root_in[k][RW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            rad_reg[k]  <= rad_in[k];
            root_reg[k] <= root_next[k];
            rem_reg[k]  <= rem_next[k];
            word_reg[k] <= word_in[k];
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_word = word_reg[NS-1];
    assign root     = root_reg[NS-1];

endmodule

[hdl/ivf_checker.sv]
module ivf_checker #(
    parameter int FRAC_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  ivf_pkg::in_word_t     item,
    input  logic                  done,
    input  ivf_pkg::out_word_t    result
);
    localparam int LAT = ivf_pkg::FRONT_STAGES + FRAC_BITS + 1 + ivf_pkg::BLEND_STAGES
                         + 2 * ivf_pkg::VAR_W + ivf_pkg::ROOT_W + ivf_pkg::OUT_STAGES;

    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_word_out : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word gave no result");

    a_no_extra : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without accepted word");

    a_meas_between : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($signed(result.fused_meas) >= $signed($past(item.meas_a, LAT))
                   && $signed(result.fused_meas) <= $signed($past(item.meas_b, LAT)))
                  || ($signed(result.fused_meas) >= $signed($past(item.meas_b, LAT))
                   && $signed(result.fused_meas) <= $signed($past(item.meas_a, LAT)))))
        else $error("fused measurement outside sensor range");

    a_sigma_bound : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.fused_sigma <= $past(item.sigma_a, LAT)
                  && result.fused_sigma <= $past(item.sigma_b, LAT)))
        else $error("fused deviation above a sensor deviation");

endmodule

bind inverse_variance_fusion ivf_checker #(.FRAC_BITS(FRAC_BITS)) u_ivf_checker (.*);

[dv/inverse_variance_fusion_test.sv]
`timescale 1ns / 1ps

module inverse_variance_fusion_test;

    localparam int DATA_W = ivf_pkg::DATA_W;
    localparam int SIG_W = ivf_pkg::SIG_W;
    localparam int VAR_W = ivf_pkg::VAR_W;
    localparam int SUM_W = ivf_pkg::SUM_W;
    localparam int FRAC = 24;
    localparam int LATENCY = FRAC + 243;
    localparam logic [SIG_W-1:0] SIG_MAX = {SIG_W{1'b1}};
    localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ivf_pkg::in_word_t item;
    logic done;
    ivf_pkg::out_word_t result;

    ivf_pkg::in_word_t pending_words[$];
    ivf_pkg::out_word_t fused_expected[$];
    idle_mode_t idle_mode;
    bit hold_send;
    int fail_count;
    int words_sent;
    int words_checked;
    int degen_seen;

    inverse_variance_fusion #(.FRAC_BITS(FRAC)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // blend toward x_a by alpha, floor rounding, result stays between inputs
    function automatic logic signed [DATA_W-1:0] weigh(
        input logic [FRAC:0] alpha,
        input logic signed [DATA_W-1:0] xa,
        input logic signed [DATA_W-1:0] xb
    );
        logic signed [DATA_W+FRAC+2:0] prod;
        logic signed [DATA_W:0] diff;
        begin
            diff = (DATA_W+1)'(xa) - (DATA_W+1)'(xb);
            prod = (DATA_W+FRAC+3)'($signed({1'b0, alpha})) * (DATA_W+FRAC+3)'(diff);
            return xb + DATA_W'(prod >>> FRAC);
        end
    endfunction

    function automatic ivf_pkg::out_word_t fuse(input ivf_pkg::in_word_t w);
        logic [VAR_W-1:0] var_a;
        logic [VAR_W-1:0] var_b;
        logic [SUM_W-1:0] var_sum;
        logic [SUM_W+FRAC-1:0] num;
        logic [FRAC:0] alpha;
        logic [2*VAR_W-1:0] prod;
        logic [2*VAR_W-1:0] quot;
        logic [SIG_W:0] root;
        logic [SIG_W:0] trial;
        ivf_pkg::out_word_t r;
        begin
            var_a = VAR_W'(w.sigma_a) * VAR_W'(w.sigma_a);
            var_b = VAR_W'(w.sigma_b) * VAR_W'(w.sigma_b);
            var_sum = SUM_W'(var_a) + SUM_W'(var_b);
            r.fused_sigma = '0;
            r.degenerate = 1'b0;
            if (var_sum == 0)
            begin
                alpha = (FRAC+1)'(1) << (FRAC - 1);
                r.degenerate = 1'b1;
            end
            else
            begin
                num = (SUM_W+FRAC)'(var_b) << FRAC;
                alpha = (FRAC+1)'(num / (SUM_W+FRAC)'(var_sum));
                prod = (2*VAR_W)'(var_a) * (2*VAR_W)'(var_b);
                quot = prod / (2*VAR_W)'(var_sum);
                root = '0;
                for (int b = SIG_W; b >= 0; b--)
                begin
                    trial = root | ((SIG_W+1)'(1) << b);
                    if ((2*VAR_W)'(trial) * (2*VAR_W)'(trial) <= quot)
                        root = trial;
                end
                r.fused_sigma = root[SIG_W-1:0];
            end
            r.fused_meas = weigh(alpha, w.meas_a, w.meas_b);
            r.fused_err = weigh(alpha, w.err_a, w.err_b);
            return r;
        end
    endfunction

    function automatic logic [SIG_W-1:0] rand_sigma();
        logic [SIG_W-1:0] v;
        begin
            v = SIG_W'({$urandom, $urandom});
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = v >> $urandom_range(0, SIG_W - 1);
                2: v = SIG_MAX;
                default: v = v >> $urandom_range(0, 30);
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_data();
        logic signed [DATA_W-1:0] v;
        begin
            v = DATA_W'({$urandom, $urandom});
            case ($urandom_range(0, 7))
                0: v = DMAX;
                1: v = DMIN;
                2: v = v >>> $urandom_range(0, DATA_W - 1);
                default: ;
            endcase
            return v;
        end
    endfunction

    function automatic ivf_pkg::in_word_t make_word(
        input logic signed [DATA_W-1:0] ma, input logic [SIG_W-1:0] sa,
        input logic signed [DATA_W-1:0] ea, input logic signed [DATA_W-1:0] mb,
        input logic [SIG_W-1:0] sb, input logic signed [DATA_W-1:0] eb
    );
        ivf_pkg::in_word_t w;
        begin
            w.meas_a = ma;
            w.sigma_a = sa;
            w.err_a = ea;
            w.meas_b = mb;
            w.sigma_b = sb;
            w.err_b = eb;
            return w;
        end
    endfunction

    // driver: offers the head of the queue, may idle at random
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                void'(pending_words.pop_front());
            if (pending_words.size() == 0 || hold_send)
                start <= 1'b0;
            else if ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 55) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 20))
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                item <= pending_words[0];
            end
        end
    end

    // model the accepted word at the same edge the block takes it
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            fused_expected.push_back(fuse(item));
            words_sent++;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        ivf_pkg::out_word_t exp_word;
        if (rst_n && done)
        begin
            if (fused_expected.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                fail_count++;
            end
            else
            begin
                exp_word = fused_expected.pop_front();
                words_checked++;
                if (result.degenerate)
                    degen_seen++;
                if (result.fused_meas !== exp_word.fused_meas)
                begin
                    $display("%0t: fused_meas expected %h actual %h", $time,
                             exp_word.fused_meas, result.fused_meas);
                    fail_count++;
                end
                if (result.fused_sigma !== exp_word.fused_sigma)
                begin
                    $display("%0t: fused_sigma expected %h actual %h", $time,
                             exp_word.fused_sigma, result.fused_sigma);
                    fail_count++;
                end
                if (result.fused_err !== exp_word.fused_err)
                begin
                    $display("%0t: fused_err expected %h actual %h", $time,
                             exp_word.fused_err, result.fused_err);
                    fail_count++;
                end
                if (result.degenerate !== exp_word.degenerate)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             exp_word.degenerate, result.degenerate);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #10000000;
        $display("status: fail");
        $finish;
    end

    task automatic wait_drained();
        begin
            while (pending_words.size() != 0 || start)
                @(posedge clk);
            while (fused_expected.size() != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        start = 1'b0;
        item = '0;
        rst_n = 1'b0;
        hold_send = 1'b0;
        idle_mode = IDLE_NONE;
        fail_count = 0;
        words_sent = 0;
        words_checked = 0;
        degen_seen = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words: zero deviations, one zero, equal, extremes
        pending_words.push_back(make_word(DMAX, '0, DMIN, DMIN, '0, DMAX));
        pending_words.push_back(make_word(48'sd100, '0, 48'sd5, -48'sd100, '0, -48'sd7));
        pending_words.push_back(make_word(DMAX, '0, DMAX, DMIN, 47'd1 << FRAC, DMIN));
        pending_words.push_back(make_word(DMIN, SIG_MAX, DMIN, DMAX, '0, DMAX));
        pending_words.push_back(make_word(DMAX, SIG_MAX, DMIN, DMIN, SIG_MAX, DMAX));
        pending_words.push_back(make_word(DMIN, SIG_MAX, DMAX, DMAX, 47'd1, DMIN));
        pending_words.push_back(make_word(DMAX, 47'd1, 48'sd3, DMIN, SIG_MAX, -48'sd3));
        pending_words.push_back(make_word(48'sd1 << FRAC, 47'd1 << FRAC, -48'sd1,
                                          -48'sd1 << FRAC, 47'd1 << FRAC, 48'sd2));
        pending_words.push_back(make_word(-48'sd1, 47'd3, 48'sd1, 48'sd0, 47'd4, -48'sd1));
        pending_words.push_back(make_word('0, 47'd1, '0, '0, 47'd1, '0));
        pending_words.push_back(make_word(-48'sd1, 47'd1, -48'sd1, '1, 47'd2, '1));
        pending_words.push_back(make_word(48'h555555555555, 47'h2AAAAAAAAAAA, 48'hAAAAAAAAAAAA,
                                          48'hAAAAAAAAAAAA, 47'h555555555555, 48'h555555555555));
        wait_drained();

        // random phases over idling modes
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_mode = idle_mode_t'(phase);
            for (int n = 0; n < 210; n++)
                pending_words.push_back(make_word(rand_data(), rand_sigma(), rand_data(),
                                                  rand_data(), rand_sigma(), rand_data()));
            // one pause mid phase until the pipeline empties
            if (phase == 1)
            begin
                while (pending_words.size() > 100)
                    @(posedge clk);
                hold_send = 1'b1;
                while (fused_expected.size() != 0)
                    @(posedge clk);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        repeat (LATENCY + 20) @(posedge clk);
        $display("covered %0d words, %0d checked, %0d with both deviations zero",
                 words_sent, words_checked, degen_seen);
        if (fail_count == 0 && fused_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[filelist.f]
hdl/ivf_pkg.sv
hdl/ivf_front.sv
hdl/ivf_alpha.sv
hdl/ivf_muldiv.sv
hdl/ivf_isqrt.sv
hdl/inverse_variance_fusion.sv
hdl/ivf_checker.sv
dv/inverse_variance_fusion_test.sv
